FILE: src/assert_macros.svh
// Concurrent assertion helpers, clocked on clk_i; the first is disabled in reset (rst_ni low).
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check prop at every rising edge outside reset.
`define LLM_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Check prop at every rising edge, reset included.
`define LLM_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) (prop)) else $error(msg);

`endif

FILE: src/llm_pkg.sv
package llm_pkg;

  localparam int unsigned ACT_W  = 3;
  localparam int unsigned STAT_W = 2;
  localparam int unsigned DATA_W = 32;
  localparam int unsigned CNT_W  = 5;

  typedef logic [ACT_W-1:0]  action_t;
  typedef logic [STAT_W-1:0] status_t;

  localparam action_t ACT_ADD_HEAD = 3'd0;
  localparam action_t ACT_ADD_TAIL = 3'd1;
  localparam action_t ACT_REM_HEAD = 3'd2;
  localparam action_t ACT_REM_TAIL = 3'd3;
  localparam action_t ACT_REM_VAL  = 3'd4;
  localparam action_t ACT_SEARCH   = 3'd5;

  localparam status_t ST_OK       = 2'd0;
  localparam status_t ST_EMPTY    = 2'd1;
  localparam status_t ST_FULL     = 2'd2;
  localparam status_t ST_NOTFOUND = 2'd3;

endpackage

FILE: src/linked_list_manager.sv
// Singly linked list of signed 32-bit values in a store of CAPACITY nodes.
// Input channel (in_valid_i/in_ready_o) carries action_i and value_in_i:
// add head, add tail, remove head, remove tail, remove value, search.
// Output channel (out_valid_o/out_ready_i) returns one transfer per request:
// value_out_o, status_o (ok, empty, full, not found), found_o, count_o.
// One request is worked at a time; in_ready_o is high only while idle.
// Rejected requests (full store, empty list, search of an empty list, unused
// codes) go straight to the result; adds write the new node, and an add at
// the tail then links the old tail to it; head removal reads the head node
// and frees it; tail removal, remove-value and search walk the list with one
// node memory read per cycle, over at most CAPACITY nodes. A new request is
// taken no earlier than the cycle its predecessor's result appears, so
// requests never overlap. The walk over the single read port sets the rate.
// Results sit in an output register: a stalled receiver does not stop the
// next request from being worked; only its final hand-off waits for the
// output register to drain.
// Reset empties the list and chains all nodes as free at once: a fill mark
// tracks nodes never allocated, so no clearing pass is needed. Node values
// are undefined until written.
`include "assert_macros.svh"

module linked_list_manager
  import llm_pkg::*;
#(
  parameter int unsigned CAPACITY = 16
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     in_valid_i,
  output logic                     in_ready_o,
  input  logic [ACT_W-1:0]         action_i,
  input  logic signed [DATA_W-1:0] value_in_i,
  output logic                     out_valid_o,
  input  logic                     out_ready_i,
  output logic signed [DATA_W-1:0] value_out_o,
  output logic [STAT_W-1:0]        status_o,
  output logic                     found_o,
  output logic [CNT_W-1:0]         count_o
);

  localparam int unsigned AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int unsigned IW = $clog2(CAPACITY + 1);
  localparam logic [IW-1:0] NIL = IW'(CAPACITY);

  localparam logic [3:0] S_IDLE     = 4'd0;
  localparam logic [3:0] S_ADD      = 4'd1;
  localparam logic [3:0] S_ADD_TAIL = 4'd2;
  localparam logic [3:0] S_RDHEAD   = 4'd3;
  localparam logic [3:0] S_RDTAIL   = 4'd4;
  localparam logic [3:0] S_WALKT    = 4'd5;
  localparam logic [3:0] S_UNLINK   = 4'd6;
  localparam logic [3:0] S_WALKV    = 4'd7;
  localparam logic [3:0] S_FREE     = 4'd8;
  localparam logic [3:0] S_DONE     = 4'd9;

  logic [DATA_W-1:0] node_value [CAPACITY];
  logic [IW-1:0]     node_link  [CAPACITY];

  logic [3:0]        state_q, state_d;
  logic [IW-1:0]     first_q, first_d;
  logic [IW-1:0]     last_q, last_d;
  logic [IW-1:0]     free_q, free_d;
  logic [IW-1:0]     cnt_q, cnt_d;
  logic [IW-1:0]     hw_q, hw_d;
  logic              out_valid_q, out_valid_d;

  action_t           action_q, action_d;
  logic [DATA_W-1:0] value_q, value_d;
  logic [IW-1:0]     node_q, node_d;
  logic [IW-1:0]     prev_q, prev_d;
  logic [DATA_W-1:0] res_vout_q, res_vout_d;
  status_t           res_status_q, res_status_d;
  logic              res_found_q, res_found_d;
  logic [DATA_W-1:0] out_vout_q, out_vout_d;
  status_t           out_status_q, out_status_d;
  logic              out_found_q, out_found_d;
  logic [CNT_W-1:0]  out_cnt_q, out_cnt_d;

  logic              rd_en;
  logic [IW-1:0]     rd_addr;
  logic [IW-1:0]     rd_addr_q;
  logic [DATA_W-1:0] val_rd_q;
  logic [IW-1:0]     link_rd_q;
  logic [IW-1:0]     link_eff;

  logic              lnk_we;
  logic [IW-1:0]     lnk_waddr;
  logic [IW-1:0]     lnk_wdata;
  logic              val_we;

  // untouched nodes still chain to their successor
  assign link_eff = (rd_addr_q >= hw_q) ? (rd_addr_q + 1'b1) : link_rd_q;

  always_ff @(posedge clk_i) begin
    if (rd_en) begin
      val_rd_q  <= node_value[rd_addr[AW-1:0]];
      link_rd_q <= node_link[rd_addr[AW-1:0]];
      rd_addr_q <= rd_addr;
    end
    if (lnk_we) begin
      node_link[lnk_waddr[AW-1:0]] <= lnk_wdata;
    end
    if (val_we) begin
      node_value[free_q[AW-1:0]] <= value_q;
    end
  end

  always_comb begin
    state_d      = state_q;
    first_d      = first_q;
    last_d       = last_q;
    free_d       = free_q;
    cnt_d        = cnt_q;
    hw_d         = hw_q;
    action_d     = action_q;
    value_d      = value_q;
    node_d       = node_q;
    prev_d       = prev_q;
    res_vout_d   = res_vout_q;
    res_status_d = res_status_q;
    res_found_d  = res_found_q;
    out_vout_d   = out_vout_q;
    out_status_d = out_status_q;
    out_found_d  = out_found_q;
    out_cnt_d    = out_cnt_q;
    out_valid_d  = out_valid_q && !out_ready_i;
    rd_en        = 1'b0;
    rd_addr      = first_q;
    lnk_we       = 1'b0;
    lnk_waddr    = node_q;
    lnk_wdata    = NIL;
    val_we       = 1'b0;
    in_ready_o   = 1'b0;

    unique case (state_q)
      S_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          action_d     = action_i;
          value_d      = value_in_i;
          res_vout_d   = '0;
          res_status_d = ST_OK;
          res_found_d  = 1'b0;
          prev_d       = NIL;
          node_d       = first_q;
          state_d      = S_DONE;
          case (action_i) inside
            ACT_ADD_HEAD, ACT_ADD_TAIL: begin
              if (free_q == NIL) begin
                res_status_d = ST_FULL;
              end else begin
                rd_en   = 1'b1;
                rd_addr = free_q;
                state_d = S_ADD;
              end
            end
            ACT_REM_HEAD: begin
              if (first_q == NIL) begin
                res_status_d = ST_EMPTY;
              end else begin
                rd_en   = 1'b1;
                state_d = S_RDHEAD;
              end
            end
            ACT_REM_TAIL: begin
              if (first_q == NIL || last_q == NIL) begin
                res_status_d = ST_EMPTY;
              end else begin
                rd_en   = 1'b1;
                rd_addr = last_q;
                node_d  = last_q;
                state_d = S_RDTAIL;
              end
            end
            ACT_REM_VAL: begin
              if (first_q == NIL) begin
                res_status_d = ST_EMPTY;
              end else begin
                rd_en   = 1'b1;
                state_d = S_WALKV;
              end
            end
            ACT_SEARCH: begin
              if (first_q == NIL) begin
                res_status_d = ST_NOTFOUND;
              end else begin
                rd_en   = 1'b1;
                state_d = S_WALKV;
              end
            end
            default: ;
          endcase
        end
      end
      S_ADD: begin
        val_we    = 1'b1;
        free_d    = link_eff;
        cnt_d     = cnt_q + 1'b1;
        node_d    = free_q;
        lnk_we    = 1'b1;
        lnk_waddr = free_q;
        if (free_q == hw_q) begin
          hw_d = hw_q + 1'b1;
        end
        state_d = S_DONE;
        if (first_q == NIL) begin
          first_d = free_q;
          last_d  = free_q;
        end else if (action_q == ACT_ADD_HEAD) begin
          lnk_wdata = first_q;
          first_d   = free_q;
        end else begin
          state_d = S_ADD_TAIL;
        end
      end
      S_ADD_TAIL: begin
        lnk_we    = 1'b1;
        lnk_waddr = last_q;
        lnk_wdata = node_q;
        last_d    = node_q;
        state_d   = S_DONE;
      end
      S_RDHEAD: begin
        res_vout_d = val_rd_q;
        first_d    = link_eff;
        if (link_eff >= NIL) begin
          first_d = NIL;
          last_d  = NIL;
        end
        state_d = S_FREE;
      end
      S_RDTAIL: begin
        res_vout_d = val_rd_q;
        if (first_q == node_q) begin
          first_d = NIL;
          last_d  = NIL;
          state_d = S_FREE;
        end else begin
          prev_d  = first_q;
          rd_en   = 1'b1;
          state_d = S_WALKT;
        end
      end
      S_WALKT: begin
        if (link_eff == node_q) begin
          state_d = S_UNLINK;
        end else begin
          prev_d = link_eff;
          if (link_eff < NIL) begin
            rd_en   = 1'b1;
            rd_addr = link_eff;
          end else begin
            state_d = S_FREE;
          end
        end
      end
      S_UNLINK: begin
        lnk_we    = 1'b1;
        lnk_waddr = prev_q;
        lnk_wdata = NIL;
        last_d    = prev_q;
        state_d   = S_FREE;
      end
      S_WALKV: begin
        if (val_rd_q == value_q) begin
          res_found_d = 1'b1;
          if (action_q == ACT_SEARCH) begin
            state_d = S_DONE;
          end else begin
            if (prev_q == NIL) begin
              first_d = link_eff;
            end else begin
              lnk_we    = 1'b1;
              lnk_waddr = prev_q;
              lnk_wdata = link_eff;
            end
            if (last_q == node_q) begin
              last_d = prev_q;
            end
            if (prev_q == NIL && link_eff >= NIL) begin
              first_d = NIL;
              last_d  = NIL;
            end
            state_d = S_FREE;
          end
        end else begin
          prev_d = node_q;
          node_d = link_eff;
          if (link_eff < NIL) begin
            rd_en   = 1'b1;
            rd_addr = link_eff;
          end else begin
            res_status_d = ST_NOTFOUND;
            state_d      = S_DONE;
          end
        end
      end
      S_FREE: begin
        lnk_we    = 1'b1;
        lnk_waddr = node_q;
        lnk_wdata = free_q;
        free_d    = node_q;
        cnt_d     = cnt_q - 1'b1;
        state_d   = S_DONE;
      end
      S_DONE: begin
        if (!out_valid_q || out_ready_i) begin
          out_vout_d   = res_vout_q;
          out_status_d = res_status_q;
          out_found_d  = res_found_q;
          out_cnt_d    = CNT_W'(cnt_q);
          out_valid_d  = 1'b1;
          state_d      = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      first_q     <= NIL;
      last_q      <= NIL;
      free_q      <= '0;
      cnt_q       <= '0;
      hw_q        <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      first_q     <= first_d;
      last_q      <= last_d;
      free_q      <= free_d;
      cnt_q       <= cnt_d;
      hw_q        <= hw_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    action_q     <= action_d;
    value_q      <= value_d;
    node_q       <= node_d;
    prev_q       <= prev_d;
    res_vout_q   <= res_vout_d;
    res_status_q <= res_status_d;
    res_found_q  <= res_found_d;
    out_vout_q   <= out_vout_d;
    out_status_q <= out_status_d;
    out_found_q  <= out_found_d;
    out_cnt_q    <= out_cnt_d;
  end

  assign out_valid_o = out_valid_q;
  assign value_out_o = out_vout_q;
  assign status_o    = out_status_q;
  assign found_o     = out_found_q;
  assign count_o     = out_cnt_q;

  `LLM_ASSERT(a_ends_agree, (first_q == NIL) == (last_q == NIL), "head and tail disagree on empty")
  `LLM_ASSERT(a_empty_count, (state_q == S_IDLE) |-> ((first_q == NIL) == (cnt_q == '0)), "empty list with nonzero count")
  `LLM_ASSERT(a_full_count, (state_q == S_IDLE) |-> ((free_q == NIL) == (cnt_q == NIL)), "free list and count disagree")
  `LLM_ASSERT(a_fill_mark, (cnt_q <= hw_q) && (hw_q <= NIL), "count beyond fill mark")

endmodule

FILE: tb/linked_list_manager_tb.sv
`timescale 1ns / 1ps

module linked_list_manager_tb;
  import llm_pkg::*;

  localparam int unsigned LIST_DEPTH   = 16;
  localparam int unsigned CYCLE_LIMIT  = 250000;
  localparam int unsigned DRAIN_CYCLES = 40;
  localparam int unsigned HOLD_CYCLES  = 300;
  localparam int unsigned RANDOM_ITEMS = 1150;
  localparam int unsigned MAX_PRINTS   = 50;

  localparam action_t ACT_UNUSED_6 = 3'd6;
  localparam action_t ACT_UNUSED_7 = 3'd7;

  typedef struct packed {
    logic signed [DATA_W-1:0] value_out;
    status_t                  status;
    logic                     found;
    logic [CNT_W-1:0]         count;
  } list_result_t;

  typedef struct {
    action_t                  act;
    logic signed [DATA_W-1:0] val;
    int                       reps;
    bit                       typed;
    list_result_t             want;
  } stim_row_t;

  logic                     clk_i;
  logic                     rst_ni      = 1'b0;
  logic                     in_valid_i  = 1'b0;
  logic                     in_ready_o;
  action_t                  action_i    = ACT_ADD_HEAD;
  logic signed [DATA_W-1:0] value_in_i  = '0;
  logic                     out_valid_o;
  logic                     out_ready_i = 1'b0;
  logic signed [DATA_W-1:0] value_out_o;
  logic [STAT_W-1:0]        status_o;
  logic                     found_o;
  logic [CNT_W-1:0]         count_o;

  logic signed [DATA_W-1:0] held_values[$];
  list_result_t             pending_replies[$];
  stim_row_t                stim_rows[$];
  int unsigned              mismatch_count = 0;
  int unsigned              cycle_count    = 0;
  bit                       no_idle        = 1'b0;
  bit                       hold_req       = 1'b0;

  logic signed [DATA_W-1:0] value_pool[8] = '{
    32'sd0, -32'sd1, 32'sd1, 32'sh7fffffff, 32'sh80000000, 32'sd5, -32'sd5, 32'sd100
  };

  linked_list_manager #(
    .CAPACITY(LIST_DEPTH)
  ) u_dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .action_i   (action_i),
    .value_in_i (value_in_i),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .value_out_o(value_out_o),
    .status_o   (status_o),
    .found_o    (found_o),
    .count_o    (count_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("Mismatches found");
      $finish;
    end
  end

  function automatic list_result_t apply_list_request(action_t act,
                                                      logic signed [DATA_W-1:0] val);
    list_result_t r;
    int           hit;
    int           k;
    r        = '0;
    r.status = ST_OK;
    hit      = -1;
    for (k = 0; k < held_values.size(); k++) begin
      if (hit < 0 && held_values[k] == val) hit = k;
    end
    case (act)
      ACT_ADD_HEAD, ACT_ADD_TAIL: begin
        if (held_values.size() == LIST_DEPTH) r.status = ST_FULL;
        else if (act == ACT_ADD_HEAD) held_values.push_front(val);
        else held_values.push_back(val);
      end
      ACT_REM_HEAD: begin
        if (held_values.size() == 0) r.status = ST_EMPTY;
        else r.value_out = held_values.pop_front();
      end
      ACT_REM_TAIL: begin
        if (held_values.size() == 0) r.status = ST_EMPTY;
        else r.value_out = held_values.pop_back();
      end
      ACT_REM_VAL: begin
        if (held_values.size() == 0) begin
          r.status = ST_EMPTY;
        end else if (hit < 0) begin
          r.status = ST_NOTFOUND;
        end else begin
          r.found = 1'b1;
          held_values.delete(hit);
        end
      end
      ACT_SEARCH: begin
        if (hit < 0) r.status = ST_NOTFOUND;
        else r.found = 1'b1;
      end
      default: begin
      end
    endcase
    r.count = CNT_W'(held_values.size());
    return r;
  endfunction

  function automatic void add_row(action_t act, logic signed [DATA_W-1:0] val, int reps,
                                  bit typed, logic signed [DATA_W-1:0] w_val,
                                  status_t w_st, bit w_found, int w_cnt);
    stim_row_t row;
    row.act            = act;
    row.val            = val;
    row.reps           = reps;
    row.typed          = typed;
    row.want.value_out = w_val;
    row.want.status    = w_st;
    row.want.found     = w_found;
    row.want.count     = CNT_W'(w_cnt);
    stim_rows.push_back(row);
  endfunction

  task automatic report_mismatch(string field, logic [DATA_W-1:0] got,
                                 logic [DATA_W-1:0] want);
    if (mismatch_count < MAX_PRINTS) begin
      $display("MISMATCH %s: got %0h want %0h at cycle %0d", field, got, want, cycle_count);
    end
    mismatch_count++;
  endtask

  task automatic send_request(action_t act, logic signed [DATA_W-1:0] val,
                              bit fixed_want, list_result_t want);
    list_result_t predicted;
    bit           taken;
    if (!no_idle && $urandom_range(0, 99) < 24) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    action_i   <= act;
    value_in_i <= val;
    taken = 1'b0;
    while (!taken) begin
      @(negedge clk_i);
      taken = in_ready_o;
      @(posedge clk_i);
    end
    predicted = apply_list_request(act, val);
    pending_replies.push_back(fixed_want ? want : predicted);
  endtask

  // Receiver: random stalls, a quiet stretch, and one long hold-off.
  initial begin
    forever begin
      @(posedge clk_i);
      if (hold_req) begin
        out_ready_i <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk_i);
        hold_req = 1'b0;
      end else begin
        out_ready_i <= no_idle || ($urandom_range(0, 99) >= 24);
      end
    end
  end

  initial begin
    list_result_t want;
    forever begin
      @(negedge clk_i);
      if (rst_ni && out_valid_o && out_ready_i) begin
        if (pending_replies.size() == 0) begin
          report_mismatch("unexpected transfer", value_out_o, '0);
        end else begin
          want = pending_replies.pop_front();
          if (value_out_o !== want.value_out)
            report_mismatch("value_out", value_out_o, want.value_out);
          if (status_o !== want.status) report_mismatch("status", status_o, want.status);
          if (found_o !== want.found) report_mismatch("found", found_o, want.found);
          if (count_o !== want.count) report_mismatch("count", count_o, want.count);
        end
      end
    end
  end

  initial begin
    action_t                  act;
    logic signed [DATA_W-1:0] val;
    list_result_t             none;
    int                       r;
    int                       k;
    int                       coin;
    bit                       grow;

    none = '0;
    add_row(ACT_REM_HEAD, 0, 1, 1, 0, ST_EMPTY, 0, 0);
    add_row(ACT_REM_TAIL, 0, 1, 1, 0, ST_EMPTY, 0, 0);
    add_row(ACT_REM_VAL, 5, 1, 1, 0, ST_EMPTY, 0, 0);
    add_row(ACT_SEARCH, 0, 1, 1, 0, ST_NOTFOUND, 0, 0);
    add_row(ACT_UNUSED_6, -1, 1, 1, 0, ST_OK, 0, 0);
    add_row(ACT_UNUSED_7, 0, 1, 1, 0, ST_OK, 0, 0);
    add_row(ACT_ADD_HEAD, 32'sh7fffffff, 1, 1, 0, ST_OK, 0, 1);
    add_row(ACT_ADD_TAIL, 32'sh80000000, 1, 1, 0, ST_OK, 0, 2);
    add_row(ACT_SEARCH, 32'sh80000000, 1, 1, 0, ST_OK, 1, 2);
    add_row(ACT_REM_TAIL, 0, 1, 1, 32'sh80000000, ST_OK, 0, 1);
    add_row(ACT_REM_HEAD, 0, 1, 1, 32'sh7fffffff, ST_OK, 0, 0);
    add_row(ACT_ADD_HEAD, 3, 1, 0, 0, ST_OK, 0, 0);
    add_row(ACT_ADD_TAIL, -1, 14, 0, 0, ST_OK, 0, 0);
    add_row(ACT_ADD_TAIL, 0, 1, 1, 0, ST_OK, 0, 16);
    add_row(ACT_ADD_HEAD, 9, 1, 1, 0, ST_FULL, 0, 16);
    add_row(ACT_ADD_TAIL, 9, 1, 1, 0, ST_FULL, 0, 16);
    add_row(ACT_SEARCH, 9, 1, 1, 0, ST_NOTFOUND, 0, 16);
    add_row(ACT_REM_VAL, -1, 1, 0, 0, ST_OK, 0, 0);
    add_row(ACT_REM_VAL, 0, 1, 0, 0, ST_OK, 0, 0);
    add_row(ACT_REM_TAIL, 0, 1, 0, 0, ST_OK, 0, 0);
    add_row(ACT_ADD_TAIL, 42, 1, 0, 0, ST_OK, 0, 0);
    add_row(ACT_REM_VAL, 3, 1, 0, 0, ST_OK, 0, 0);
    add_row(ACT_REM_VAL, 12345, 1, 1, 0, ST_NOTFOUND, 0, 13);
    add_row(ACT_REM_HEAD, 0, 16, 0, 0, ST_OK, 0, 0);
    add_row(ACT_ADD_TAIL, 1, 1, 0, 0, ST_OK, 0, 0);
    add_row(ACT_REM_VAL, 1, 1, 0, 0, ST_OK, 0, 0);
    add_row(ACT_REM_TAIL, 0, 1, 1, 0, ST_EMPTY, 0, 0);

    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (stim_rows[i]) begin
      for (k = 0; k < stim_rows[i].reps; k++) begin
        send_request(stim_rows[i].act, stim_rows[i].val, stim_rows[i].typed,
                     stim_rows[i].want);
      end
    end

    grow = 1'b1;
    for (k = 0; k < RANDOM_ITEMS; k++) begin
      no_idle = (k >= 300 && k < 550);
      if (k == 700) hold_req = 1'b1;
      if (k == 950) begin
        in_valid_i <= 1'b0;
        while (pending_replies.size() != 0) @(posedge clk_i);
      end

      if (held_values.size() == LIST_DEPTH) grow = 1'b0;
      else if (held_values.size() == 0) grow = 1'b1;
      else if ($urandom_range(0, 99) < 4) grow = ~grow;

      r = $urandom_range(0, 99);
      coin = $urandom_range(0, 2);
      if (r < 3) begin
        act = r[0] ? ACT_UNUSED_7 : ACT_UNUSED_6;
      end else if ((r < 60) == grow) begin
        act = $urandom_range(0, 1) ? ACT_ADD_TAIL : ACT_ADD_HEAD;
      end else if (r < 80) begin
        act = (coin == 0) ? ACT_REM_HEAD : (coin == 1) ? ACT_REM_TAIL : ACT_REM_VAL;
      end else begin
        act = ACT_SEARCH;
      end

      coin = $urandom_range(0, 99);
      if ((act == ACT_REM_VAL || act == ACT_SEARCH) && held_values.size() != 0 &&
          coin < 50) begin
        val = held_values[$urandom_range(0, held_values.size() - 1)];
      end else if (coin < 85) begin
        val = value_pool[$urandom_range(0, 7)];
      end else begin
        val = $urandom;
      end

      send_request(act, val, 1'b0, none);
    end

    in_valid_i <= 1'b0;
    no_idle = 1'b0;
    while (pending_replies.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (mismatch_count == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
